// ----- rtl/core/alsd_pkg.sv -----
// ----------------------------------------------------------------------------
// alsd_pkg
// Shared widths, register map, reset values and item types for the adaptive
// loud sound detector.
// ----------------------------------------------------------------------------
package alsd_pkg;

   // field widths
   localparam int TICK_W     = 32;
   localparam int LEVEL_W    = 32;
   localparam int RATIO_W    = 16;
   localparam int ALPHA_W    = 16;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // product widths: level x 16-bit coefficient
   localparam int PROD_W     = LEVEL_W + RATIO_W;
   localparam int THR_W      = PROD_W - 12;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATIO       = 3'd0,
      CSR_MIN_TRIGGER = 3'd1,
      CSR_RISE_ALPHA  = 3'd2,
      CSR_FALL_ALPHA  = 3'd3,
      CSR_WARMUP      = 3'd4,
      CSR_RUN_NEEDED  = 3'd5,
      CSR_COOLDOWN    = 3'd6,
      CSR_LOG_PERIOD  = 3'd7
   } csr_index_type;

   // reset values of the configuration registers
   localparam logic [RATIO_W-1:0] RATIO_RST       = 16'd12953;
   localparam logic [LEVEL_W-1:0] MIN_TRIGGER_RST = 32'd2048000;
   localparam logic [ALPHA_W-1:0] RISE_ALPHA_RST  = 16'd1311;
   localparam logic [ALPHA_W-1:0] FALL_ALPHA_RST  = 16'd6554;
   localparam logic [COUNT_W-1:0] WARMUP_RST      = 8'd8;
   localparam logic [COUNT_W-1:0] RUN_NEEDED_RST  = 8'd4;
   localparam logic [TICK_W-1:0]  COOLDOWN_RST    = 32'd120000;
   localparam logic [TICK_W-1:0]  LOG_PERIOD_RST  = 32'd1000;

   // rounding constants for Q4.12 and Q0.16 products
   localparam logic [PROD_W-1:0]  THR_ROUND = PROD_W'(2048);
   localparam logic [PROD_W-1:0]  EMA_ROUND = PROD_W'(32768);

   typedef struct packed {
      logic [TICK_W-1:0]  log_period_ticks;
      logic [TICK_W-1:0]  cooldown_ticks;
      logic [COUNT_W-1:0] loud_run_needed;
      logic [COUNT_W-1:0] warmup_count;
      logic [ALPHA_W-1:0] fall_alpha_q16;
      logic [ALPHA_W-1:0] rise_alpha_q16;
      logic [LEVEL_W-1:0] min_trigger_q8;
      logic [RATIO_W-1:0] ratio_q12;
   } cfg_type;

   typedef struct packed {
      logic               read_failed;
      logic [TICK_W-1:0]  now_tick;
      logic [LEVEL_W-1:0] rms_q8;
   } item_type;

   typedef struct packed {
      logic               alarm_event;
      logic               warning_event;
      logic [COUNT_W-1:0] loud_run;
      logic               loud;
      logic               armed;
      logic [LEVEL_W-1:0] threshold_q8;
   } result_type;

endpackage

// ----- rtl/core/adaptive_loud_sound_detector.sv -----
// ----------------------------------------------------------------------------
// adaptive_loud_sound_detector
// Per-window loud sound detection against an adaptive noise baseline.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one beat per audio window: RMS level, tick and a read
//   failure flag. rsp_ returns exactly one beat per request beat, in order:
//   threshold, loud-run count and the armed / loud / warning / alarm flags.
//   csr_ writes one configuration register per beat and is always ready;
//   write it only while no window is in flight.
//   A request beat passes an input register, then one pass of compare
//   and multiply logic into the output register, where the detector state
//   is updated as well. One window is taken every cycle while the receiver
//   keeps up; the state loop closes within that single pass.
//   When the receiver stalls, the output register holds its beat and the
//   input register still takes one more window; after that req_tready drops
//   until rsp_tready returns.
//   Synchronous reset clears the baseline, warmup count, loud run and tick
//   history, drops both valid flags and loads the default configuration.
// ----------------------------------------------------------------------------
module adaptive_loud_sound_detector (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,  // rms_q8, now_tick
   input  logic                            req_tuser,  // read_failed
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,  // threshold_q8, loud_run
   output logic [3:0]                      rsp_tuser,  // armed, loud,
                                                       // warning_event, alarm_event
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [alsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alsd_pkg::CSR_DATA_W-1:0] csr_data
);

   alsd_pkg::cfg_type    cfg;
   alsd_pkg::item_type   item_ff, item_in;
   alsd_pkg::result_type res_ff, res_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 req_beat;
   logic                 advance;

   alsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   alsd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (res_in)
   );

   // handshake: input register feeds the output register when it has room
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_valid_in  = req_beat || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   // unpack request beat
   always_comb begin
      item_in             = item_ff;
      if (req_beat) begin
         item_in.rms_q8      = req_tdata[31:0];
         item_in.now_tick    = req_tdata[63:32];
         item_in.read_failed = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         res_ff <= res_in;
      end
   end

   // pack response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {res_ff.loud_run, res_ff.threshold_q8};
   assign rsp_tuser  = {res_ff.alarm_event, res_ff.warning_event,
                        res_ff.loud, res_ff.armed};

   // a held window is not dropped while the output is stalled
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input beat lost while stalled");

   // a window moved forward always appears at the output
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced beat missing at output");

   // a stalled response beat holds its contents
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response beat changed");

endmodule

// ----- rtl/core/alsd_csr.sv -----
// ----------------------------------------------------------------------------
// alsd_csr
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
module alsd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [alsd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [alsd_pkg::CSR_DATA_W-1:0] csr_data,
   output alsd_pkg::cfg_type               cfg
);

   alsd_pkg::cfg_type cfg_ff;
   alsd_pkg::cfg_type cfg_in;

   // always ready: every beat is a single register write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            alsd_pkg::CSR_RATIO:
               cfg_in.ratio_q12 = csr_data[alsd_pkg::RATIO_W-1:0];
            alsd_pkg::CSR_MIN_TRIGGER:
               cfg_in.min_trigger_q8 = csr_data[alsd_pkg::LEVEL_W-1:0];
            alsd_pkg::CSR_RISE_ALPHA:
               cfg_in.rise_alpha_q16 = csr_data[alsd_pkg::ALPHA_W-1:0];
            alsd_pkg::CSR_FALL_ALPHA:
               cfg_in.fall_alpha_q16 = csr_data[alsd_pkg::ALPHA_W-1:0];
            alsd_pkg::CSR_WARMUP:
               cfg_in.warmup_count = csr_data[alsd_pkg::COUNT_W-1:0];
            alsd_pkg::CSR_RUN_NEEDED:
               cfg_in.loud_run_needed = csr_data[alsd_pkg::COUNT_W-1:0];
            alsd_pkg::CSR_COOLDOWN:
               cfg_in.cooldown_ticks = csr_data[alsd_pkg::TICK_W-1:0];
            alsd_pkg::CSR_LOG_PERIOD:
               cfg_in.log_period_ticks = csr_data[alsd_pkg::TICK_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ratio_q12        <= alsd_pkg::RATIO_RST;
         cfg_ff.min_trigger_q8   <= alsd_pkg::MIN_TRIGGER_RST;
         cfg_ff.rise_alpha_q16   <= alsd_pkg::RISE_ALPHA_RST;
         cfg_ff.fall_alpha_q16   <= alsd_pkg::FALL_ALPHA_RST;
         cfg_ff.warmup_count     <= alsd_pkg::WARMUP_RST;
         cfg_ff.loud_run_needed  <= alsd_pkg::RUN_NEEDED_RST;
         cfg_ff.cooldown_ticks   <= alsd_pkg::COOLDOWN_RST;
         cfg_ff.log_period_ticks <= alsd_pkg::LOG_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/alsd_core.sv -----
// ----------------------------------------------------------------------------
// alsd_core
// Detector state and the single-pass window update: warmup seeding,
// threshold, asymmetric EMA, loud-run counter, warning and alarm events.
// ----------------------------------------------------------------------------
module alsd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  alsd_pkg::item_type   item,
   input  alsd_pkg::cfg_type    cfg,
   output alsd_pkg::result_type result
);

   // detector state
   logic [alsd_pkg::LEVEL_W-1:0] baseline_ff, baseline_in;
   logic [alsd_pkg::COUNT_W-1:0] warmup_ff,   warmup_in;
   logic [alsd_pkg::COUNT_W-1:0] run_ff,      run_in;
   logic [alsd_pkg::TICK_W-1:0]  event_ff,    event_in;
   logic [alsd_pkg::TICK_W-1:0]  period_ff,   period_in;

   logic                         seeding;
   logic [alsd_pkg::LEVEL_W-1:0] base_seed;
   logic [alsd_pkg::COUNT_W-1:0] warmup_next;
   logic [alsd_pkg::PROD_W-1:0]  thr_prod;
   logic [alsd_pkg::THR_W-1:0]   thr_wide;
   logic [alsd_pkg::LEVEL_W-1:0] thr_sat;
   logic [alsd_pkg::LEVEL_W-1:0] thr;
   logic                         armed;
   logic                         loud;
   logic                         falling;
   logic [alsd_pkg::LEVEL_W-1:0] ema_diff;
   logic [alsd_pkg::ALPHA_W-1:0] ema_alpha;
   logic [alsd_pkg::PROD_W-1:0]  ema_prod;
   logic [alsd_pkg::LEVEL_W-1:0] ema_delta;
   logic [alsd_pkg::LEVEL_W-1:0] ema_level;
   logic [alsd_pkg::TICK_W-1:0]  since_event;
   logic [alsd_pkg::TICK_W-1:0]  since_period;
   logic                         cooldown;
   logic                         period_due;
   logic [alsd_pkg::COUNT_W-1:0] run_step;
   logic                         warn;
   logic                         alarm;

   // warmup: seed with the smallest level seen
   assign seeding     = warmup_ff < cfg.warmup_count;
   assign base_seed   = (seeding && (baseline_ff == '0 || item.rms_q8 < baseline_ff))
                        ? item.rms_q8 : baseline_ff;
   assign warmup_next = seeding ? warmup_ff + 8'd1 : warmup_ff;

   // threshold = max(sat(baseline * ratio), floor), Q4.12 rounded
   assign thr_prod = alsd_pkg::PROD_W'(base_seed) * alsd_pkg::PROD_W'(cfg.ratio_q12)
                     + alsd_pkg::THR_ROUND;
   assign thr_wide = thr_prod[alsd_pkg::PROD_W-1:12];
   assign thr_sat  = (|thr_wide[alsd_pkg::THR_W-1:alsd_pkg::LEVEL_W])
                     ? '1 : thr_wide[alsd_pkg::LEVEL_W-1:0];
   assign thr      = (thr_sat < cfg.min_trigger_q8) ? cfg.min_trigger_q8 : thr_sat;

   assign armed = warmup_next >= cfg.warmup_count;
   assign loud  = armed && (item.rms_q8 > thr);

   // one shared EMA multiplier; direction picks the distance and weight
   assign falling   = item.rms_q8 < base_seed;
   assign ema_diff  = falling ? base_seed - item.rms_q8 : item.rms_q8 - base_seed;
   assign ema_alpha = falling ? cfg.fall_alpha_q16 : cfg.rise_alpha_q16;
   assign ema_prod  = alsd_pkg::PROD_W'(ema_diff) * alsd_pkg::PROD_W'(ema_alpha)
                      + alsd_pkg::EMA_ROUND;
   assign ema_delta = ema_prod[alsd_pkg::PROD_W-1:16];

   always_comb begin
      if (base_seed == '0) begin
         ema_level = item.rms_q8;
      end else if (falling) begin
         ema_level = base_seed - ema_delta;
      end else if (item.rms_q8 < thr) begin
         ema_level = base_seed + ema_delta;
      end else begin
         ema_level = base_seed;
      end
   end

   // tick distances, modulo the tick width
   assign since_event  = item.now_tick - event_ff;
   assign since_period = item.now_tick - period_ff;
   assign cooldown     = (event_ff != '0) && (since_event < cfg.cooldown_ticks);
   assign period_due   = since_period >= cfg.log_period_ticks;

   assign run_step = loud ? ((run_ff == '1) ? run_ff : run_ff + 8'd1) : '0;

   // next state and result
   always_comb begin
      baseline_in = baseline_ff;
      warmup_in   = warmup_ff;
      run_in      = run_ff;
      event_in    = event_ff;
      period_in   = period_ff;
      warn        = 1'b0;
      alarm       = 1'b0;

      if (item.read_failed) begin
         alarm = !cooldown;
         if (alarm) begin
            event_in = item.now_tick;
         end
      end else begin
         baseline_in = loud ? base_seed : ema_level;
         warmup_in   = warmup_next;
         if (period_due) begin
            run_in    = run_step;
            period_in = item.now_tick;
            warn      = loud && (run_step >= cfg.loud_run_needed) && !cooldown;
            if (warn) begin
               event_in = item.now_tick;
               run_in   = '0;
            end
         end
      end

      result.threshold_q8  = item.read_failed ? '0 : thr;
      result.armed         = item.read_failed ? (warmup_ff >= cfg.warmup_count) : armed;
      result.loud          = !item.read_failed && loud;
      result.loud_run      = run_in;
      result.warning_event = warn;
      result.alarm_event   = alarm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= '0;
         warmup_ff   <= '0;
         run_ff      <= '0;
         event_ff    <= '0;
         period_ff   <= '0;
      end else if (step_en) begin
         baseline_ff <= baseline_in;
         warmup_ff   <= warmup_in;
         run_ff      <= run_in;
         event_ff    <= event_in;
         period_ff   <= period_in;
      end
   end

   // a warning restarts the loud run
   a_warn_clears_run: assert property (@(posedge clock) disable iff (reset)
      step_en && result.warning_event |=> run_ff == '0)
      else $error("loud run not cleared after warning");

   // warmup count only moves up
   a_warmup_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> warmup_ff >= $past(warmup_ff))
      else $error("warmup count went down");

   // a failed read leaves the baseline alone
   a_fail_keeps_baseline: assert property (@(posedge clock) disable iff (reset)
      step_en && item.read_failed |=> $stable(baseline_ff))
      else $error("baseline moved on a failed read");

endmodule
